// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; included by pdec_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is asserted.
`define PDEC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define PDEC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pdec_pkg.sv -----
// Shared types, constants and helper functions of the percent decoder.
// No dependencies; imported by the core, front, queue and back modules.
`timescale 1ns / 1ps
`default_nettype none

package pdec_pkg;

    localparam int CNT_W           = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_DATA        = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = 16'hFFFF;

    localparam logic [7:0] CHAR_PCT  = 8'h25;  // '%'
    localparam logic [7:0] CHAR_W    = 8'h57;  // 'W' = 'a' - 10
    localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // One queue entry: the beats caused by one accepted input byte.
    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] data;   // decoded bytes, data[0] first
        logic [1:0]               n_data; // number of valid data bytes
        logic                     term;   // terminator beat follows the data
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - CHAR_ZERO;
        end else begin
            t = (c | CASE_BIT) - CHAR_W;
        end
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pdec_in_if.sv -----
// Input channel of the percent decoder: one encoded byte per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pdec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pdec_out_if.sv -----
// Output channel of the percent decoder: one decoded byte per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pdec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/url_percent_decoder_core.sv -----
// Streaming URL percent decoder, top level.
// Depends on pdec_pkg, pdec_in_if, pdec_out_if, pdec_front, pdec_queue, pdec_back.
//
// Usage:
//   i_in  : encoded text, one byte per beat, in_last on the final byte.
//   o_out : decoded text, one byte per beat; after the final input byte a zero
//           beat with out_last high ends the text.
//   i_cfg_we / i_cfg_wdata : destination size (reset 65535); at most that minus
//           one decoded bytes leave per text, the rest is dropped. Write only
//           while the block is idle.
// Timing:
//   An input beat is taken in every cycle while the entry queue has room
//   (QUEUE_DEPTH entries). Each input beat makes zero to four output beats,
//   which leave one per cycle while the receiver takes them; output bandwidth
//   sets the sustained rate. Beats pass the queue, then the output register.
// Reset (synchronous, active low) empties the queue, drops the output beat,
//   clears the escape state and byte count and restores the destination size.
// A stalled receiver holds the output register; the queue keeps taking input
//   until it is full, then i_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder_core
    import pdec_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    pdec_in_if.sink               i_in,
    pdec_out_if.source            o_out
);

    t_push  push;
    t_entry head;
    logic   q_full;
    logic   q_empty;
    logic   pop;

    // Front: escape decode and capacity cut, one beat per cycle while queue has room.
    pdec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in.valid),
        .i_byte      (i_in.in_byte),
        .i_last      (i_in.in_last),
        .i_q_full    (q_full),
        .o_ready     (i_in.ready),
        .o_push      (push)
    );

    // Queue decouples input acceptance from output beats.
    pdec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: serialize each entry, output register toward the receiver.
    pdec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_byte  (o_out.out_byte),
        .o_last  (o_out.out_last)
    );

endmodule

`default_nettype wire

// ----- rtl/pdec_front.sv -----
// Front end: escape state machine, capacity limit and queue entry build.
// Depends on pdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdec_front
    import pdec_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    input  wire logic             i_q_full,
    output logic                  o_ready,
    output t_push                 o_push
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_held, n_held;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap;

    logic             accept;
    logic [3:0][7:0]  d;
    logic [1:0]       nd;
    logic [CNT_W-1:0] limit, room;
    logic [1:0]       k;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        d       = '0;
        nd      = 2'd0;
        case (r_phase)
            PH_PCT: begin
                if (is_hex(i_byte)) begin
                    n_held  = i_byte;
                    n_phase = PH_DIGIT;
                end else begin
                    d[0] = CHAR_PCT;
                    if (i_byte == CHAR_PCT) begin
                        nd      = 2'd1;
                        n_phase = PH_PCT;
                    end else begin
                        d[1]    = i_byte;
                        nd      = 2'd2;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_DIGIT: begin
                if (is_hex(i_byte)) begin
                    d[0]    = {hex_val(r_held), hex_val(i_byte)};
                    nd      = 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    d[0] = CHAR_PCT;
                    d[1] = r_held;
                    if (i_byte == CHAR_PCT) begin
                        nd      = 2'd2;
                        n_phase = PH_PCT;
                    end else begin
                        d[2]    = i_byte;
                        nd      = 2'd3;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                if (i_byte == CHAR_PCT) begin
                    n_phase = PH_PCT;
                end else begin
                    d[0]    = i_byte;
                    nd      = 2'd1;
                    n_phase = PH_IDLE;
                end
            end
        endcase

        // end of text: flush a cut escape as plain bytes
        if (i_last) begin
            if (n_phase == PH_PCT) begin
                d[nd] = CHAR_PCT;
                nd    = nd + 2'd1;
            end else if (n_phase == PH_DIGIT) begin
                d[0] = CHAR_PCT;
                d[1] = n_held;
                nd   = 2'd2;
            end
            n_phase = PH_IDLE;
            n_held  = '0;
        end
    end

    // capacity: keep only the prefix that still fits
    always_comb begin
        limit = (r_cap == '0) ? '0 : r_cap - 1'b1;
        room  = (r_count < limit) ? limit - r_count : '0;
        k     = (room < {{(CNT_W-2){1'b0}}, nd}) ? room[1:0] : nd;
        if (i_last) begin
            n_count = '0;
        end else begin
            n_count = r_count + {{(CNT_W-2){1'b0}}, k};
        end
    end

    always_comb begin
        o_push.valid        = accept && ((k != 2'd0) || i_last);
        o_push.entry.data   = d[MAX_DATA-1:0];
        o_push.entry.n_data = k;
        o_push.entry.term   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pdec_queue.sv -----
// Short entry queue between the front end and the output sequencer.
// Depends on pdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdec_queue
    import pdec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output t_entry     o_head,
    output logic       o_empty,
    output logic       o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_fill, n_fill;
    logic            do_push, do_pop;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_fill = r_fill + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pdec_back.sv -----
// Output sequencer: head entry to output register, one beat per cycle unless stalled.
// Depends on pdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdec_back
    import pdec_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_byte,
    output logic        o_last
);

    logic [1:0]      r_idx, n_idx;
    logic            r_valid, n_valid;
    logic [7:0]      r_byte;
    logic            r_last;
    logic            load;
    logic [3:0][7:0] pad;
    logic [2:0]      n_beats;
    logic [1:0]      end_idx;
    logic [7:0]      beat_byte;
    logic            beat_last;

    assign pad     = {8'h00, i_head.data};
    assign n_beats = {1'b0, i_head.n_data} + {2'b00, i_head.term};
    assign end_idx = 2'(n_beats - 3'd1);

    always_comb begin
        if (r_idx < i_head.n_data) begin
            beat_byte = pad[r_idx];
            beat_last = 1'b0;
        end else begin
            beat_byte = '0;
            beat_last = 1'b1;
        end
    end

    assign load  = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && (r_idx == end_idx);

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = o_pop ? 2'd0 : r_idx + 2'd1;
        end
        if (load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= beat_byte;
            r_last <= beat_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ----- rtl/pdec_checker.sv -----
// Port-level checks of the percent decoder, bound to the top level.
// Depends on assert_macros.svh and url_percent_decoder_core.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pdec_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // a beat waiting on the receiver stays offered
    `PDEC_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid, "output beat withdrawn")

    // reset leaves nothing to send
    `PDEC_ASSERT_ALWAYS(a_rst_idle, i_clk,
        !i_rst_n |=> !i_out_valid, "output beat after reset")

    // reset leaves the queue empty, so input is taken right away
    `PDEC_ASSERT_ALWAYS(a_rst_ready, i_clk,
        !i_rst_n |=> i_in_ready, "input not ready after reset")

    // the end-of-text beat is the zero terminator
    `PDEC_ASSERT(a_term_zero, i_clk, i_rst_n,
        i_out_valid && i_out_last |-> i_out_byte == 8'h00, "terminator not zero")

endmodule

bind url_percent_decoder_core pdec_checker u_pdec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

`default_nettype wire
